FILE: design/crt_pkg.sv
// Shared types and constants for the cubic retarget trajectory block.
// No dependencies; imported by crt_mac and cubic_retarget_trajectory.
`timescale 1ns / 1ps

package crt_pkg;

    localparam int POS_W     = 24;
    localparam int STEP_W    = 17;
    localparam int ACC_GUARD = 4;

    typedef logic signed [POS_W-1:0] t_pos;

    localparam logic [STEP_W-1:0] STEP_RESET = 17'd1092;

    localparam t_pos CENTER_X = 24'sd131072;
    localparam t_pos CENTER_Y = 24'sd92160;
    localparam t_pos POS_MAX  = 24'sd8388607;
    localparam t_pos POS_MIN  = -24'sd8388608;

endpackage

FILE: design/crt_mac.sv
// Shared multiply-accumulate unit: res = floor(a * t / 2^PHASE_BITS) + b.
// One narrow multiplier used twice per operation (low then high half of a).
// Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_mac #(
    parameter int PHASE_BITS = 16,
    parameter int COEF_WIDTH = 40
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  logic signed [COEF_WIDTH+crt_pkg::ACC_GUARD-1:0] i_a,
    input  logic signed [COEF_WIDTH+crt_pkg::ACC_GUARD-1:0] i_b,
    input  logic        [PHASE_BITS-1:0]                    i_t,
    output logic                                           o_done,
    output logic signed [COEF_WIDTH+crt_pkg::ACC_GUARD-1:0] o_res
);
    import crt_pkg::*;

    localparam int ACC_W  = COEF_WIDTH + ACC_GUARD;
    localparam int LO_W   = ACC_W / 2;
    localparam int HI_W   = ACC_W - LO_W;
    localparam int MOP_W  = LO_W + 1;
    localparam int PROD_W = MOP_W + PHASE_BITS + 1;
    localparam int FULL_W = ACC_W + PHASE_BITS + 1;

    logic signed [HI_W-1:0]       r_ahi;
    logic signed [ACC_W-1:0]      r_b;
    logic signed [PROD_W-1:0]     r_plo;
    logic signed [PROD_W-1:0]     r_phi;
    logic signed [ACC_W-1:0]      r_res;
    logic                         r_s1;
    logic                         r_s2;
    logic                         r_done;

    logic signed [MOP_W-1:0]      m_a;
    logic signed [PHASE_BITS:0]   m_t;
    logic signed [PROD_W-1:0]     prod;
    logic signed [FULL_W-1:0]     full;
    logic signed [FULL_W-1:0]     quot;
    logic signed [ACC_W-1:0]      n_res;

    assign m_a  = i_start ? $signed({1'b0, i_a[LO_W-1:0]}) : MOP_W'(r_ahi);
    assign m_t  = $signed({1'b0, i_t});
    assign prod = PROD_W'(m_a * m_t);

    assign full  = (FULL_W'(r_phi) <<< LO_W) + FULL_W'(r_plo);
    assign quot  = full >>> PHASE_BITS;
    assign n_res = ACC_W'(quot) + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_s2   <= r_s1;
            r_done <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_plo <= prod;
            r_ahi <= i_a[ACC_W-1:LO_W];
            r_b   <= i_b;
        end
        if (r_s1) begin
            r_phi <= prod;
        end
        if (r_s2) begin
            r_res <= n_res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: design/cubic_retarget_trajectory.sv
// Top level of the two-axis cubic Hermite trajectory generator.
// Holds segment state and the sequencer; depends on crt_pkg and crt_mac.
`timescale 1ns / 1ps

// Each accepted item is one frame tick and yields one position result. The
// work is done by the single shared multiply-accumulate unit: every Horner step
// runs a low half product, a high half product and a shift and add, the
// position needs three steps per axis and the retarget velocity two more per
// axis, plus one coefficient build state per axis. The input is stalled while a
// tick is in progress; a finished result waits in the output register without
// blocking the next transfer.
module cubic_retarget_trajectory #(
    parameter int PHASE_BITS = 16,
    parameter int COEF_WIDTH = 40
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [crt_pkg::STEP_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  crt_pkg::t_pos              i_target_x,
    input  crt_pkg::t_pos              i_target_y,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output crt_pkg::t_pos              o_pos_x,
    output crt_pkg::t_pos              o_pos_y,
    output logic                       o_segment_ended,
    output logic                       o_saturated
);
    import crt_pkg::*;

    localparam int ACC_W = COEF_WIDTH + ACC_GUARD;
    localparam int SUM_W = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;

    localparam logic [SUM_W-1:0] PHASE_ONE = SUM_W'(1) << PHASE_BITS;
    localparam logic signed [ACC_W-1:0] C_MAX =
        ACC_W'((64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] C_MIN = -C_MAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] P_MAX = ACC_W'(POS_MAX);
    localparam logic signed [ACC_W-1:0] P_MIN = ACC_W'(POS_MIN);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VEL   = 3'd1;
    localparam logic [2:0] S_BUILD = 3'd2;
    localparam logic [2:0] S_POS   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;

    logic [2:0]            r_state;
    logic                  r_axis;
    logic [1:0]            r_k;
    logic                  r_kick;
    logic [STEP_W-1:0]     r_step;
    logic [PHASE_BITS-1:0] r_phase;
    t_pos                  r_c0   [0:1];
    t_coef                 r_c1   [0:1];
    t_coef                 r_c2   [0:1];
    t_coef                 r_c3   [0:1];
    t_pos                  r_last [0:1];
    t_pos                  r_goal [0:1];
    t_pos                  r_tgt  [0:1];
    t_coef                 r_vel;
    logic                  r_ended;
    logic                  r_sat;
    logic                  r_out_valid;
    t_pos                  r_pos_x;
    t_pos                  r_pos_y;
    logic                  r_out_ended;
    logic                  r_out_sat;

    logic                    accept;
    logic                    out_load;
    logic [SUM_W-1:0]        phase_sum;
    logic                    phase_end;
    logic [1:0]              step_idx;
    logic                    last_k;
    logic                    mac_start;
    logic                    mac_done;
    logic signed [ACC_W-1:0] mac_a;
    logic signed [ACC_W-1:0] mac_b;
    logic signed [ACC_W-1:0] mac_res;
    logic signed [ACC_W-1:0] c1_e;
    logic signed [ACC_W-1:0] c2_e;
    logic signed [ACC_W-1:0] c3_e;
    logic signed [ACC_W-1:0] vel_e;
    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] c2_raw;
    logic signed [ACC_W-1:0] c3_raw;
    t_coef                   vel_clip;
    logic                    vel_sat;
    t_pos                    pos_clip;
    logic                    pos_sat;
    t_coef                   c2_clip;
    logic                    c2_sat;
    t_coef                   c3_clip;
    logic                    c3_sat;

    assign accept    = i_in_valid && !o_in_stall;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign phase_sum = SUM_W'(r_phase) + SUM_W'(r_step);
    assign phase_end = phase_sum >= PHASE_ONE;

    assign c1_e  = ACC_W'(r_c1[r_axis]);
    assign c2_e  = ACC_W'(r_c2[r_axis]);
    assign c3_e  = ACC_W'(r_c3[r_axis]);
    assign vel_e = ACC_W'(r_vel);

    assign step_idx  = r_kick ? 2'd0 : r_k + 2'd1;
    assign last_k    = (r_state == S_VEL) ? (r_k == 2'd1) : (r_k == 2'd2);
    assign mac_start = ((r_state == S_VEL) || (r_state == S_POS))
                       && (r_kick || (mac_done && !last_k));

    always_comb begin
        mac_a = mac_res;
        mac_b = c1_e;
        if (r_state == S_VEL) begin
            if (step_idx == 2'd0) begin
                mac_a = c3_e + (c3_e <<< 1);
                mac_b = c2_e <<< 1;
            end
        end else begin
            unique case (step_idx)
                2'd0: begin
                    mac_a = c3_e;
                    mac_b = c2_e;
                end
                2'd1: mac_b = c1_e;
                default: mac_b = ACC_W'(r_c0[r_axis]);
            endcase
        end
    end

    crt_mac #(
        .PHASE_BITS (PHASE_BITS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .i_t     (r_phase),
        .o_done  (mac_done),
        .o_res   (mac_res)
    );

    assign diff   = ACC_W'(r_tgt[r_axis]) - ACC_W'(r_last[r_axis]);
    assign c2_raw = diff + (diff <<< 1) - (vel_e <<< 1);
    assign c3_raw = vel_e - (diff <<< 1);

    always_comb begin
        vel_sat = (mac_res > C_MAX) || (mac_res < C_MIN);
        priority if (mac_res > C_MAX) vel_clip = COEF_WIDTH'(C_MAX);
        else if (mac_res < C_MIN)     vel_clip = COEF_WIDTH'(C_MIN);
        else                          vel_clip = COEF_WIDTH'(mac_res);

        pos_sat = (mac_res > P_MAX) || (mac_res < P_MIN);
        priority if (mac_res > P_MAX) pos_clip = POS_MAX;
        else if (mac_res < P_MIN)     pos_clip = POS_MIN;
        else                          pos_clip = POS_W'(mac_res);

        c2_sat = (c2_raw > C_MAX) || (c2_raw < C_MIN);
        priority if (c2_raw > C_MAX) c2_clip = COEF_WIDTH'(C_MAX);
        else if (c2_raw < C_MIN)     c2_clip = COEF_WIDTH'(C_MIN);
        else                         c2_clip = COEF_WIDTH'(c2_raw);

        c3_sat = (c3_raw > C_MAX) || (c3_raw < C_MIN);
        priority if (c3_raw > C_MAX) c3_clip = COEF_WIDTH'(C_MAX);
        else if (c3_raw < C_MIN)     c3_clip = COEF_WIDTH'(C_MIN);
        else                         c3_clip = COEF_WIDTH'(c3_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_k         <= 2'd0;
            r_kick      <= 1'b0;
            r_step      <= STEP_RESET;
            r_phase     <= '0;
            r_c0[0]     <= CENTER_X;
            r_c0[1]     <= CENTER_Y;
            r_c1[0]     <= '0;
            r_c1[1]     <= '0;
            r_c2[0]     <= '0;
            r_c2[1]     <= '0;
            r_c3[0]     <= '0;
            r_c3[1]     <= '0;
            r_last[0]   <= CENTER_X;
            r_last[1]   <= CENTER_Y;
            r_goal[0]   <= CENTER_X;
            r_goal[1]   <= CENTER_Y;
            r_ended     <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end

            if (mac_start) begin
                r_k    <= step_idx;
                r_kick <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tgt[0] <= i_target_x;
                        r_tgt[1] <= i_target_y;
                        r_ended  <= phase_end;
                        r_sat    <= 1'b0;
                        r_axis   <= 1'b0;
                        r_kick   <= 1'b1;
                        if (phase_end) begin
                            r_phase <= '0;
                            r_c0[0] <= r_goal[0];
                            r_c0[1] <= r_goal[1];
                            r_c1[0] <= '0;
                            r_c1[1] <= '0;
                            r_c2[0] <= '0;
                            r_c2[1] <= '0;
                            r_c3[0] <= '0;
                            r_c3[1] <= '0;
                        end else begin
                            r_phase <= phase_sum[PHASE_BITS-1:0];
                        end
                        r_state <= i_mode ? S_VEL : S_POS;
                    end
                end
                S_VEL: begin
                    if (mac_done && last_k) begin
                        r_vel   <= vel_clip;
                        r_sat   <= r_sat | vel_sat;
                        r_state <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    r_c0[r_axis]   <= r_last[r_axis];
                    r_c1[r_axis]   <= r_vel;
                    r_c2[r_axis]   <= c2_clip;
                    r_c3[r_axis]   <= c3_clip;
                    r_goal[r_axis] <= r_tgt[r_axis];
                    r_sat          <= r_sat | c2_sat | c3_sat;
                    r_kick         <= 1'b1;
                    if (r_axis == 1'b0) begin
                        r_axis  <= 1'b1;
                        r_state <= S_VEL;
                    end else begin
                        r_axis  <= 1'b0;
                        r_phase <= '0;
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    if (mac_done && last_k) begin
                        r_last[r_axis] <= pos_clip;
                        r_sat          <= r_sat | pos_sat;
                        if (r_axis == 1'b0) begin
                            r_axis <= 1'b1;
                            r_kick <= 1'b1;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_pos_x     <= r_last[0];
            r_pos_y     <= r_last[1];
            r_out_ended <= r_ended;
            r_out_sat   <= r_sat;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_pos_x;
    assign o_pos_y         = r_pos_y;
    assign o_segment_ended = r_out_ended;
    assign o_saturated     = r_out_sat;

endmodule
